// File: hw/rtl/maqr_pkg.sv
package maqr_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 8;

  // item codes on the action input
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEL    = 2'd0,
    KIND_MOVE_TO  = 2'd1,
    KIND_MOVE_BY  = 2'd2,
    KIND_RUN_TIME = 2'd3
  } kind_t;

  // one queued motion action
  typedef struct packed {
    kind_t              kind;
    logic        [14:0] accel;
    logic signed [15:0] speed;
    logic signed [31:0] pos;
    logic        [31:0] run_ms;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic signed [15:0] SPEED_MAX = 16'sh7fff;
  localparam logic signed [15:0] SPEED_MIN = -16'sh8000;

endpackage

// File: hw/rtl/motion_action_queue_ramp_core.sv
// Motion action queue with a linear speed ramp. Push items (action = 0) append
// one motion action (accelerate, move to, move by, run for time) to a circular
// queue of QUEUE_DEPTH entries and are refused when the queue is full. Tick
// items (action = 1) carry the elapsed milliseconds and the measured position
// and work on the head action: its first tick latches target speed, signed
// acceleration, absolute target position and travel direction (elapsed time
// counts as zero on that tick), later ticks ramp the commanded speed by
// acceleration times elapsed time and clamp at the target. A finished action
// is popped and counted. Every item yields exactly one result. The block takes
// one item per clock cycle unless an unread result stalls it; the update is a
// 17x17 multiply, one add and the clamps between the input handshake and the
// result register. The queue lives in a RAM with a registered read port that
// always prefetches the next head entry, with a write bypass for a push into an
// empty queue, so no item waits on the read. Nothing needs clearing after reset.
module motion_action_queue_ramp_core #(
  parameter int QUEUE_DEPTH = maqr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [1:0]         act_type,
  input  logic [14:0]        act_accel,
  input  logic signed [15:0] act_speed,
  input  logic signed [31:0] act_pos,
  input  logic [31:0]        act_run_ms,
  input  logic [15:0]        elapsed_ms,
  input  logic signed [31:0] motor_pos,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] speed_cmd,
  output logic               push_accepted,
  output logic               action_done,
  output logic [1:0]         done_kind,
  output logic [3:0]         queue_count,
  output logic               queue_empty,
  output logic [15:0]        completed_total
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // queue bookkeeping
  logic [AW-1:0] head_ptr, head_ptr_next;
  logic [AW-1:0] tail_ptr, tail_ptr_next;
  logic [CW-1:0] entry_count, entry_count_next;

  // head action working state
  logic                      head_started, head_started_next;
  maqr_pkg::kind_t           work_kind, work_kind_next;
  logic signed [16:0]        work_accel, work_accel_next;
  logic signed [15:0]        work_target_speed, work_target_speed_next;
  logic signed [31:0]        work_target_pos, work_target_pos_next;
  logic [31:0]               work_remaining_ms, work_remaining_ms_next;
  logic                      ramp_upward, ramp_upward_next;
  logic                      travel_upward, travel_upward_next;
  logic signed [15:0]        cur_speed, cur_speed_next;
  logic [15:0]               done_counter, done_counter_next;

  logic in_fire;
  logic push_ok, tick_ok, done;

  // head entry prefetch and bypass
  maqr_pkg::entry_t new_entry, head_entry, byp_data;
  logic [maqr_pkg::ENTRY_W-1:0] ram_rdata;
  logic byp_valid;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign new_entry.kind   = maqr_pkg::kind_t'(act_type);
  assign new_entry.accel  = act_accel;
  assign new_entry.speed  = act_speed;
  assign new_entry.pos    = act_pos;
  assign new_entry.run_ms = act_run_ms;

  assign push_ok = in_fire && (action == maqr_pkg::ACT_PUSH) &&
                   (entry_count < CW'(QUEUE_DEPTH));
  assign tick_ok = in_fire && (action == maqr_pkg::ACT_TICK) && (entry_count != '0);

  // read address follows the head after this cycle so the entry is ready next cycle
  maqr_ram #(
    .WIDTH(maqr_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (push_ok),
    .waddr(tail_ptr),
    .wdata(new_entry),
    .raddr(head_ptr_next),
    .rdata(ram_rdata)
  );

  assign head_entry = byp_valid ? byp_data : maqr_pkg::entry_t'(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= push_ok && (tail_ptr == head_ptr_next);
    end
    byp_data <= new_entry;
  end

  // effective per-tick values: latched from the head entry on its first tick
  logic                      start;
  maqr_pkg::kind_t           kind;
  logic [15:0]               el;
  logic signed [15:0]        tgt0, tgt1;
  logic signed [16:0]        acc0, acc_mag;
  logic                      ru0;
  logic signed [31:0]        tpos0;
  logic                      tu0;
  logic [31:0]               rem0;
  logic signed [16:0]        start_mag;
  logic signed [33:0]        prod;
  logic signed [34:0]        ns, ns_clamp;
  logic signed [15:0]        ramp_speed;
  logic                      ramping;
  logic                      flip;

  always_comb begin
    start = !head_started;
    kind  = start ? head_entry.kind : work_kind;
    el    = start ? 16'd0 : elapsed_ms;
    tgt0  = start ? head_entry.speed : work_target_speed;
    rem0  = start ? head_entry.run_ms : work_remaining_ms;

    start_mag = $signed({2'b00, head_entry.accel});
    if (start) begin
      ru0 = (cur_speed < tgt0);
      if (cur_speed < tgt0) begin
        acc0 = start_mag;
      end else if (cur_speed > tgt0) begin
        acc0 = -start_mag;
      end else begin
        acc0 = '0;
      end
    end else begin
      ru0  = ramp_upward;
      acc0 = work_accel;
    end

    if (start) begin
      unique case (head_entry.kind)
        maqr_pkg::KIND_MOVE_TO: tpos0 = head_entry.pos;
        maqr_pkg::KIND_MOVE_BY: tpos0 = head_entry.pos + motor_pos;
        default:                tpos0 = motor_pos;
      endcase
      tu0 = !(motor_pos > tpos0);
    end else begin
      tpos0 = work_target_pos;
      tu0   = travel_upward;
    end
  end

  // ramp: speed + accel * elapsed, clamp at target, saturate to 16 bits
  always_comb begin
    ramping = (cur_speed != tgt0);
    prod    = acc0 * $signed({1'b0, el});
    ns      = 35'(cur_speed) + 35'(prod);
    ns_clamp = ns;
    if (!ru0) begin
      if (ns <= 35'(tgt0)) ns_clamp = 35'(tgt0);
    end else begin
      if (ns >= 35'(tgt0)) ns_clamp = 35'(tgt0);
    end
    if (ns_clamp > 35'(maqr_pkg::SPEED_MAX)) begin
      ramp_speed = maqr_pkg::SPEED_MAX;
    end else if (ns_clamp < 35'(maqr_pkg::SPEED_MIN)) begin
      ramp_speed = maqr_pkg::SPEED_MIN;
    end else begin
      ramp_speed = ns_clamp[15:0];
    end
    cur_speed_next = ramping ? ramp_speed : cur_speed;
  end

  // completion, move direction flips, run time countdown
  always_comb begin
    done   = !ramping && (kind == maqr_pkg::KIND_ACCEL);
    flip   = 1'b0;
    tgt1   = tgt0;
    rem1_calc: begin end
    work_remaining_ms_next = rem0;
    unique case (kind)
      maqr_pkg::KIND_MOVE_TO, maqr_pkg::KIND_MOVE_BY: begin
        if (!tu0) begin
          if (motor_pos <= tpos0) begin
            done = 1'b1;
          end else if (tgt0 > 16'sd0) begin
            flip = 1'b1;
            tgt1 = -tgt0;
          end
        end else begin
          if (motor_pos >= tpos0) begin
            done = 1'b1;
          end else if (tgt0 < 16'sd0) begin
            flip = 1'b1;
            tgt1 = (tgt0 == maqr_pkg::SPEED_MIN) ? maqr_pkg::SPEED_MAX : -tgt0;
          end
        end
      end
      maqr_pkg::KIND_RUN_TIME: begin
        if (32'(el) >= rem0) begin
          done = 1'b1;
        end else begin
          work_remaining_ms_next = rem0 - 32'(el);
        end
      end
      default: begin
      end
    endcase
  end

  // re-aim the ramp after a flip, from the speed just commanded
  always_comb begin
    acc_mag          = acc0[16] ? -acc0 : acc0;
    work_accel_next  = acc0;
    ramp_upward_next = ru0;
    if (flip) begin
      if (cur_speed_next < tgt1) begin
        ramp_upward_next = 1'b1;
        work_accel_next  = acc_mag;
      end else if (cur_speed_next > tgt1) begin
        ramp_upward_next = 1'b0;
        work_accel_next  = -acc_mag;
      end else begin
        work_accel_next  = '0;
      end
    end
    work_target_speed_next = tgt1;
    work_target_pos_next   = tpos0;
    travel_upward_next     = tu0;
    work_kind_next         = kind;
    head_started_next      = !done;
  end

  // queue pointers and counters
  always_comb begin
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    entry_count_next  = entry_count;
    done_counter_next = done_counter;
    if (push_ok) begin
      tail_ptr_next    = (tail_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
      entry_count_next = entry_count + 1'b1;
    end else if (tick_ok && done) begin
      head_ptr_next     = (head_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
      entry_count_next  = entry_count - 1'b1;
      done_counter_next = done_counter + 1'b1;
    end
  end

  logic [CW+3:0] count_ext;
  assign count_ext = {4'b0000, entry_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr          <= '0;
      tail_ptr          <= '0;
      entry_count       <= '0;
      cur_speed         <= '0;
      head_started      <= 1'b0;
      work_kind         <= maqr_pkg::KIND_ACCEL;
      work_accel        <= '0;
      work_target_speed <= '0;
      work_target_pos   <= '0;
      work_remaining_ms <= '0;
      ramp_upward       <= 1'b0;
      travel_upward     <= 1'b1;
      done_counter      <= '0;
      out_valid         <= 1'b0;
    end else begin
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      entry_count  <= entry_count_next;
      done_counter <= done_counter_next;
      // hold the head working state unless a tick works on it
      if (tick_ok) begin
        cur_speed         <= cur_speed_next;
        head_started      <= head_started_next;
        work_kind         <= work_kind_next;
        work_accel        <= work_accel_next;
        work_target_speed <= work_target_speed_next;
        work_target_pos   <= work_target_pos_next;
        work_remaining_ms <= work_remaining_ms_next;
        ramp_upward       <= ramp_upward_next;
        travel_upward     <= travel_upward_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: load on every accepted transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      speed_cmd       <= tick_ok ? cur_speed_next : cur_speed;
      push_accepted   <= push_ok;
      action_done     <= tick_ok && done;
      done_kind       <= (tick_ok && done) ? kind : maqr_pkg::KIND_ACCEL;
      queue_count     <= count_ext[3:0];
      queue_empty     <= (entry_count_next == '0);
      completed_total <= done_counter_next;
    end
  end

endmodule

// File: hw/rtl/maqr_ram.sv
module maqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
